// ===== rtl/bdpc_pkg.sv =====
`default_nettype none

package bdpc_pkg;

  // Default counter width for stability and hold timers
  localparam int TIMER_WIDTH_DEF = 16;

  // Configuration register widths and index
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int HOLD_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } cfg_reg_t;

  // Register values after reset
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  // Raw pin levels (active low button)
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_press_classifier_unit.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_stall  | raw_level
// out     | out_valid / out_stall| short_press, long_press, pressed, hold_ticks
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction per clock sustained while the result is not stalled; an
// accepted input is registered in the input register, then in the result register.
// State advances in the single cycle an item leaves the input register, so
// consecutive ticks flow back to back.
// Synchronous active-high reset restores config, state and valid registers to defaults.
// A stalled result holds the result register; in_stall rises only while both
// registers hold an item and the result is stalled.
`default_nettype none

module button_debounce_press_classifier_unit #(
  parameter int TIMER_WIDTH = bdpc_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           raw_level,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                short_press,
  output logic                                long_press,
  output logic                                pressed,
  output logic [bdpc_pkg::HOLD_W-1:0]         hold_ticks
);

  // Compare width covers both the timers and the 16-bit settings
  localparam int CMP_W = (TIMER_WIDTH > bdpc_pkg::CFG_W) ? TIMER_WIDTH : bdpc_pkg::CFG_W;
  localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] HOLD_MAX = CMP_W'({bdpc_pkg::HOLD_W{1'b1}});

  // configuration registers
  logic [bdpc_pkg::CFG_W-1:0] debounce_ticks;
  logic [bdpc_pkg::CFG_W-1:0] long_press_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdpc_pkg::DEBOUNCE_RST;
      long_press_ticks <= bdpc_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (bdpc_pkg::cfg_reg_t'(cfg_index))
        bdpc_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        bdpc_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register and flow control
  logic in_q_valid;
  logic raw_q;
  logic advance;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      raw_q <= raw_level;
    end
  end

  // classifier state
  logic                   last_raw;
  logic [TIMER_WIDTH-1:0] stable_count;
  logic                   debounced_level;
  logic [TIMER_WIDTH-1:0] press_timer;
  logic                   long_fired;

  logic                   last_raw_next;
  logic [TIMER_WIDTH-1:0] stable_count_next;
  logic                   debounced_level_next;
  logic [TIMER_WIDTH-1:0] press_timer_next;
  logic                   long_fired_next;

  logic [TIMER_WIDTH-1:0]      stable_eff;
  logic [TIMER_WIDTH-1:0]      timer_eff;
  logic                        fired_eff;
  logic                        level_taken;
  logic                        short_pulse;
  logic                        long_pulse;
  logic [CMP_W-1:0]            timer_wide;
  logic [bdpc_pkg::HOLD_W-1:0] hold_val;

  // one tick of debounce and press classification
  always_comb begin
    last_raw_next = raw_q;
    stable_eff    = (raw_q != last_raw) ? '0 : stable_count;

    level_taken = (CMP_W'(stable_eff) >= CMP_W'(debounce_ticks)) &&
                  (raw_q != debounced_level);
    debounced_level_next = level_taken ? raw_q : debounced_level;

    timer_eff   = press_timer;
    fired_eff   = long_fired;
    short_pulse = 1'b0;
    if (level_taken) begin
      if (raw_q == bdpc_pkg::LVL_PRESSED) begin
        timer_eff = '0;
        fired_eff = 1'b0;
      end else begin
        short_pulse = (CMP_W'(press_timer) < CMP_W'(long_press_ticks)) && !long_fired;
      end
    end

    // long press fires once per hold
    long_pulse = (debounced_level_next == bdpc_pkg::LVL_PRESSED) && !fired_eff &&
                 (CMP_W'(timer_eff) >= CMP_W'(long_press_ticks));
    long_fired_next = fired_eff || long_pulse;

    timer_wide = CMP_W'(timer_eff);
    hold_val   = '0;
    if (debounced_level_next == bdpc_pkg::LVL_PRESSED) begin
      hold_val = (timer_wide > HOLD_MAX) ? {bdpc_pkg::HOLD_W{1'b1}}
                                         : timer_wide[bdpc_pkg::HOLD_W-1:0];
    end

    // saturating counters
    stable_count_next = (stable_eff == CNT_MAX) ? CNT_MAX : stable_eff + TIMER_WIDTH'(1);
    press_timer_next  = timer_eff;
    if (debounced_level_next == bdpc_pkg::LVL_PRESSED && timer_eff != CNT_MAX) begin
      press_timer_next = timer_eff + TIMER_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= bdpc_pkg::LVL_RELEASED;
      stable_count    <= '0;
      debounced_level <= bdpc_pkg::LVL_RELEASED;
      press_timer     <= '0;
      long_fired      <= 1'b0;
    end else if (advance) begin
      last_raw        <= last_raw_next;
      stable_count    <= stable_count_next;
      debounced_level <= debounced_level_next;
      press_timer     <= press_timer_next;
      long_fired      <= long_fired_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      short_press <= short_pulse;
      long_press  <= long_pulse;
      pressed     <= (debounced_level_next == bdpc_pkg::LVL_PRESSED);
      hold_ticks  <= hold_val;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdpc_checker.sv =====
`default_nettype none

module bdpc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           short_press,
  input wire logic                           long_press,
  input wire logic                           pressed,
  input wire logic [bdpc_pkg::HOLD_W-1:0]    hold_ticks
);

  // a stalled input transaction stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> in_valid)
    else $error("input transaction withdrawn while stalled");

  // a short press is reported on the release tick
  a_short_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && short_press) |-> !pressed)
    else $error("short press while still pressed");

  // a long press is reported while held
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_press) |-> pressed)
    else $error("long press while released");

  // hold duration reads zero when released
  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pressed) |-> (hold_ticks == '0))
    else $error("hold ticks nonzero while released");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .short_press (short_press),
  .long_press  (long_press),
  .pressed     (pressed),
  .hold_ticks  (hold_ticks)
);

`default_nettype wire

// ===== tb/tb_button_debounce_press_classifier_unit.sv =====
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier_unit;

  localparam int TW          = bdpc_pkg::TIMER_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLDOFF_LEN = 60;

  typedef logic [TW-1:0] tick_cnt_t;

  typedef struct packed {
    logic                        short_pulse;
    logic                        long_pulse;
    logic                        is_pressed;
    logic [bdpc_pkg::HOLD_W-1:0] hold;
  } press_result_t;

  // Tracks the button state, predicts each tick's result and checks the DUT output
  class press_tracker;
    logic [bdpc_pkg::CFG_W-1:0] debounce_cfg;
    logic [bdpc_pkg::CFG_W-1:0] long_cfg;
    logic                       last_raw;
    tick_cnt_t                  stable_cnt;
    logic                       deb_level;
    tick_cnt_t                  press_tmr;
    logic                       long_done;
    press_result_t              pending_results[$];
    int                         failures;

    function new();
      debounce_cfg = bdpc_pkg::DEBOUNCE_RST;
      long_cfg     = bdpc_pkg::LONG_PRESS_RST;
      last_raw     = bdpc_pkg::LVL_RELEASED;
      stable_cnt   = '0;
      deb_level    = bdpc_pkg::LVL_RELEASED;
      press_tmr    = '0;
      long_done    = 1'b0;
      failures     = 0;
    endfunction

    function void set_reg(bdpc_pkg::cfg_reg_t idx, logic [bdpc_pkg::CFG_W-1:0] val);
      case (idx)
        bdpc_pkg::REG_DEBOUNCE_TICKS:   debounce_cfg = val;
        bdpc_pkg::REG_LONG_PRESS_TICKS: long_cfg = val;
        default: ;
      endcase
    endfunction

    // One tick of the debounce / classify state machine
    function press_result_t predict_tick(logic lvl);
      press_result_t r;
      r = '0;
      if (lvl != last_raw) begin
        last_raw   = lvl;
        stable_cnt = '0;
      end
      if (stable_cnt >= debounce_cfg && lvl != deb_level) begin
        deb_level = lvl;
        if (lvl == bdpc_pkg::LVL_PRESSED) begin
          press_tmr = '0;
          long_done = 1'b0;
        end else if (press_tmr < long_cfg && !long_done) begin
          r.short_pulse = 1'b1;
        end
      end
      if (deb_level == bdpc_pkg::LVL_PRESSED && !long_done && press_tmr >= long_cfg) begin
        long_done    = 1'b1;
        r.long_pulse = 1'b1;
      end
      r.is_pressed = (deb_level == bdpc_pkg::LVL_PRESSED);
      r.hold       = r.is_pressed ? press_tmr : '0;
      // saturating counters
      if (stable_cnt != '1) stable_cnt = stable_cnt + tick_cnt_t'(1);
      if (r.is_pressed && press_tmr != '1) press_tmr = press_tmr + tick_cnt_t'(1);
      return r;
    endfunction

    function void take_tick(logic lvl);
      pending_results.push_back(predict_tick(lvl));
    endfunction

    function void check_result(logic sp, logic lp, logic pr,
                               logic [bdpc_pkg::HOLD_W-1:0] ht);
      press_result_t e;
      if (pending_results.size() == 0) begin
        $error({"result with no transaction outstanding: ",
                "short_press %0d long_press %0d pressed %0d hold_ticks %0d"},
               sp, lp, pr, ht);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      if (sp !== e.short_pulse) begin
        $error("short_press: expected %0d, actual %0d", e.short_pulse, sp);
        failures++;
      end
      if (lp !== e.long_pulse) begin
        $error("long_press: expected %0d, actual %0d", e.long_pulse, lp);
        failures++;
      end
      if (pr !== e.is_pressed) begin
        $error("pressed: expected %0d, actual %0d", e.is_pressed, pr);
        failures++;
      end
      if (ht !== e.hold) begin
        $error("hold_ticks: expected %0d, actual %0d", e.hold, ht);
        failures++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index = bdpc_pkg::REG_DEBOUNCE_TICKS;
  logic [bdpc_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           raw_level = bdpc_pkg::LVL_RELEASED;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           short_press;
  logic                           long_press;
  logic                           pressed;
  logic [bdpc_pkg::HOLD_W-1:0]    hold_ticks;

  press_tracker tracker = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        holdoff_go = 1'b0;
  logic        holdoff_done = 1'b0;
  int          holdoff_left = 0;
  int unsigned cycle_count = 0;
  int unsigned ticks_sent = 0;
  logic        cur_level = bdpc_pkg::LVL_RELEASED;
  int          cur_debounce = int'(bdpc_pkg::DEBOUNCE_RST);
  int          cur_long = int'(bdpc_pkg::LONG_PRESS_RST);

  button_debounce_press_classifier_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_level   (raw_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .short_press (short_press),
    .long_press  (long_press),
    .pressed     (pressed),
    .hold_ticks  (hold_ticks)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_go && !holdoff_done) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      out_stall    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(short_press, long_press, pressed, hold_ticks);
  end

  // Offer one tick; returns once the transaction is accepted
  task automatic send_tick(input logic lvl);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_tick(lvl);
    ticks_sent++;
    cur_level = lvl;
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Stop offering and wait for every outstanding result plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [bdpc_pkg::CFG_W-1:0] dbc,
                            input logic [bdpc_pkg::CFG_W-1:0] lng);
    cfg_we    <= 1'b1;
    cfg_index <= bdpc_pkg::REG_DEBOUNCE_TICKS;
    cfg_data  <= dbc;
    @(posedge clk);
    tracker.set_reg(bdpc_pkg::REG_DEBOUNCE_TICKS, dbc);
    cfg_index <= bdpc_pkg::REG_LONG_PRESS_TICKS;
    cfg_data  <= lng;
    @(posedge clk);
    tracker.set_reg(bdpc_pkg::REG_LONG_PRESS_TICKS, lng);
    cfg_we <= 1'b0;
    cur_debounce = int'(dbc);
    cur_long     = int'(lng);
  endtask

  // One press or release with contact bounce, or a burst of noise
  task automatic run_episode();
    logic target;
    int   n_bounce;
    int   hold_len;
    int   dbc_cap;
    int   long_cap;
    dbc_cap  = (cur_debounce > 12) ? 12 : cur_debounce;
    long_cap = (cur_long > 40) ? 40 : cur_long;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
    end else begin
      target   = ($urandom_range(9) == 0) ? cur_level : ~cur_level;
      n_bounce = $urandom_range(0, 3);
      repeat (n_bounce) begin
        send_run(target, $urandom_range(1, 3));
        send_run(~target, $urandom_range(1, 2));
      end
      hold_len = dbc_cap + 1 + $urandom_range(0, long_cap + 4);
      send_run(target, hold_len);
    end
  endtask

  initial begin
    int sp;
    int unsigned phase_start;
    logic [bdpc_pkg::CFG_W-1:0] dbc;
    logic [bdpc_pkg::CFG_W-1:0] lng;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 35;
    recv_idle_pct <= 54;

    // Values after reset: a short press is not yet debounced
    send_run(bdpc_pkg::LVL_PRESSED, 2);
    send_tick(bdpc_pkg::LVL_RELEASED);
    drain();

    // Zero debounce and zero long threshold: immediate accept, long on press
    set_config(16'd0, 16'd0);
    send_run(bdpc_pkg::LVL_PRESSED, 2);
    send_run(bdpc_pkg::LVL_RELEASED, 2);
    drain();

    // Bouncy press released at the long threshold: neither short nor long press
    set_config(16'd2, 16'd4);
    send_tick(bdpc_pkg::LVL_PRESSED);
    send_tick(bdpc_pkg::LVL_RELEASED);
    send_run(bdpc_pkg::LVL_PRESSED, 4);
    send_run(bdpc_pkg::LVL_RELEASED, 3);
    drain();

    // Held past threshold: long press, no short on release
    set_config(16'd0, 16'd2);
    send_run(bdpc_pkg::LVL_PRESSED, 4);
    send_run(bdpc_pkg::LVL_RELEASED, 2);
    drain();

    // Maximum settings: a short run of presses is not accepted
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_config(16'hFFFF, 16'hFFFF);
    send_run(bdpc_pkg::LVL_PRESSED, 20);
    drain();
    set_config(16'd0, 16'hFFFF);
    send_run(bdpc_pkg::LVL_RELEASED, 3);
    drain();

    // Random presses over a range of settings and idle patterns
    for (sp = 0; sp < 12; sp++) begin
      case (sp / 4)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct <= 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct <= 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      drain();
      dbc = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      if ($urandom_range(9) == 0)      lng = 16'hFFFF;
      else if ($urandom_range(9) == 0) lng = 16'd0;
      else                             lng = 16'($urandom_range(1, 30));
      set_config(dbc, lng);
      if (sp == 8) holdoff_go <= 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 82) begin
        run_episode();
        // sender pauses until the pipeline is empty during one window of the phase
        if (sp == 5 && ticks_sent - phase_start >= 48 && ticks_sent - phase_start < 60)
          drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdpc_pkg.sv
rtl/button_debounce_press_classifier_unit.sv
rtl/bdpc_checker.sv
tb/tb_button_debounce_press_classifier_unit.sv
